// File: sv/ultrasonic_echo_ranger_assert.svh
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define UER_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define UER_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/uer_pkg.sv
`timescale 1ns / 1ps
package uer_pkg;

  localparam int WIDTH_BITS  = 16;
  localparam int SAMPLE_BITS = 8;
  localparam int TICK_W      = 20;
  localparam int EW_W        = WIDTH_BITS + 1;
  localparam int SUM_W       = 24;
  localparam int DIVD_W      = 24;
  localparam int DIVS_W      = 8;
  localparam int CFG_DW      = 20;
  localparam int CFG_AW      = 3;

  localparam logic [TICK_W-1:0] LOW_TICKS = 20'd2;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_TIMEOUT = 3'd0;
  localparam logic [CFG_AW-1:0] REG_NEAR    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_UPC     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_TRIGW   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SAMPLES = 3'd4;
  localparam logic [CFG_AW-1:0] REG_GAP     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MINCM   = 3'd6;
  localparam logic [CFG_AW-1:0] REG_FILTER  = 3'd7;

  // status codes
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_NEAR  = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  // ranging phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TLOW  = 3'd1;
  localparam logic [2:0] PH_THIGH = 3'd2;
  localparam logic [2:0] PH_WAIT  = 3'd3;
  localparam logic [2:0] PH_MEAS  = 3'd4;
  localparam logic [2:0] PH_GAP   = 3'd5;

  typedef struct packed {
    logic [15:0]            timeout_us;
    logic [15:0]            near_width_us;
    logic [7:0]             us_per_cm;
    logic [7:0]             trigger_width_us;
    logic [SAMPLE_BITS-1:0] sample_count;
    logic [19:0]            gap_us;
    logic [7:0]             min_valid_cm;
    logic                   filter_mode;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: sv/uer_cfg.sv
`timescale 1ns / 1ps
module uer_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [uer_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [uer_pkg::CFG_DW-1:0]    cfg_wdata,
  output uer_pkg::cfg_t                 cfg
);

  uer_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_us       <= 16'd30000;
      cfg_r.near_width_us    <= 16'd150;
      cfg_r.us_per_cm        <= 8'd58;
      cfg_r.trigger_width_us <= 8'd20;
      cfg_r.sample_count     <= uer_pkg::SAMPLE_BITS'(1);
      cfg_r.gap_us           <= 20'd20000;
      cfg_r.min_valid_cm     <= 8'd2;
      cfg_r.filter_mode      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uer_pkg::REG_TIMEOUT: cfg_r.timeout_us       <= cfg_wdata[15:0];
        uer_pkg::REG_NEAR:    cfg_r.near_width_us    <= cfg_wdata[15:0];
        uer_pkg::REG_UPC:     cfg_r.us_per_cm        <= cfg_wdata[7:0];
        uer_pkg::REG_TRIGW:   cfg_r.trigger_width_us <= cfg_wdata[7:0];
        uer_pkg::REG_SAMPLES: cfg_r.sample_count     <= cfg_wdata[uer_pkg::SAMPLE_BITS-1:0];
        uer_pkg::REG_GAP:     cfg_r.gap_us           <= cfg_wdata[19:0];
        uer_pkg::REG_MINCM:   cfg_r.min_valid_cm     <= cfg_wdata[7:0];
        uer_pkg::REG_FILTER:  cfg_r.filter_mode      <= cfg_wdata[0];
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/uer_div.sv
`timescale 1ns / 1ps
module uer_div (
  input  logic              clk,
  input  logic              rst_n,
  input  uer_pkg::div_req_t req,
  output uer_pkg::div_rsp_t rsp
);

  localparam int CNT_W = $clog2(uer_pkg::DIVD_W + 1);

  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic [uer_pkg::DIVD_W-1:0]  q_r, q_nxt;
  logic [uer_pkg::DIVS_W-1:0]  rem_r, rem_nxt;
  logic [uer_pkg::DIVS_W-1:0]  dvs_r, dvs_nxt;
  logic [uer_pkg::DIVS_W:0]    trial;
  logic [uer_pkg::DIVS_W:0]    diff;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[uer_pkg::DIVD_W-1]};
    diff     = trial - {1'b0, dvs_r};
    if (req.start) begin
      cnt_nxt = CNT_W'(uer_pkg::DIVD_W);
      q_nxt   = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[uer_pkg::DIVS_W-1:0];
        q_nxt   = {q_r[uer_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[uer_pkg::DIVS_W-1:0];
        q_nxt   = {q_r[uer_pkg::DIVD_W-2:0], 1'b0};
      end
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

// File: sv/ultrasonic_echo_ranger.sv
`timescale 1ns / 1ps
// one transfer in is one microsecond tick, one transfer out is its result
// most ticks finish without a divide; a shot end with a distance adds one divide
// a filtered run end with at least one counted shot adds a second divide
// both divides use the one shared restoring divider; no new tick is taken until the result is out
// rst_n is synchronous: registers return to defaults, ranging state clears to idle
module ultrasonic_echo_ranger (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_start_req,
  input  logic                        in_echo_level,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_trigger_level,
  output logic                        out_done_res,
  output logic [1:0]                  out_status,
  output logic [15:0]                 out_distance_cm,
  input  logic                        cfg_we,
  input  logic [uer_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [uer_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DIV1    = 3'd1;
  localparam logic [2:0] S_SHOT    = 3'd2;
  localparam logic [2:0] S_GAPOVER = 3'd3;
  localparam logic [2:0] S_DIV2    = 3'd4;

  uer_pkg::cfg_t     cfg;
  uer_pkg::div_req_t div_req;
  uer_pkg::div_rsp_t div_rsp;

  logic [2:0]                       state_r, state_nxt;
  logic [2:0]                       phase_r, phase_nxt;
  logic [uer_pkg::TICK_W-1:0]       tick_r, tick_nxt;
  logic [uer_pkg::EW_W-1:0]         ew_r, ew_nxt;
  logic [uer_pkg::SAMPLE_BITS-1:0]  shots_r, shots_nxt;
  logic [uer_pkg::SAMPLE_BITS-1:0]  valid_r, valid_nxt;
  logic [uer_pkg::SUM_W-1:0]        sum_r, sum_nxt;
  logic [1:0]                       st_r, st_nxt;
  logic [uer_pkg::EW_W-1:0]         dist_r, dist_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_trig_r, out_trig_nxt;
  logic                             out_done_r, out_done_nxt;
  logic [1:0]                       out_status_r, out_status_nxt;
  logic [15:0]                      out_dist_r, out_dist_nxt;

  logic                             in_xfer;
  logic                             fin;
  logic                             fin_trig;
  logic                             fin_done;
  logic [1:0]                       fin_st;
  logic [15:0]                      fin_dist;
  logic [uer_pkg::TICK_W-1:0]       tick_inc;
  logic [uer_pkg::EW_W-1:0]         ew_inc;
  logic [7:0]                       upc_eff;
  logic [7:0]                       tw_eff;
  logic [uer_pkg::SAMPLE_BITS-1:0]  want;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  uer_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;

  assign tick_inc = tick_r + uer_pkg::TICK_W'(1);
  assign ew_inc   = ew_r + uer_pkg::EW_W'(1);
  assign upc_eff  = (cfg.us_per_cm == 8'd0) ? 8'd1 : cfg.us_per_cm;
  assign tw_eff   = (cfg.trigger_width_us == 8'd0) ? 8'd1 : cfg.trigger_width_us;
  assign want     = (cfg.sample_count == '0) ? uer_pkg::SAMPLE_BITS'(1) : cfg.sample_count;

  always_comb begin
    state_nxt        = state_r;
    phase_nxt        = phase_r;
    tick_nxt         = tick_r;
    ew_nxt           = ew_r;
    shots_nxt        = shots_r;
    valid_nxt        = valid_r;
    sum_nxt          = sum_r;
    st_nxt           = st_r;
    dist_nxt         = dist_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_trig_nxt     = out_trig_r;
    out_done_nxt     = out_done_r;
    out_status_nxt   = out_status_r;
    out_dist_nxt     = out_dist_r;
    div_req.start    = 1'b0;
    div_req.dividend = {(uer_pkg::DIVD_W - uer_pkg::EW_W)'(0), ew_r};
    div_req.divisor  = upc_eff;
    fin              = 1'b0;
    fin_trig         = 1'b0;
    fin_done         = 1'b0;
    fin_st           = uer_pkg::ST_VALID;
    fin_dist         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (phase_r)
            uer_pkg::PH_IDLE: begin
              fin = 1'b1;
              if (in_start_req) begin
                shots_nxt = '0;
                valid_nxt = '0;
                sum_nxt   = '0;
                phase_nxt = uer_pkg::PH_TLOW;
                tick_nxt  = '0;
                ew_nxt    = '0;
              end
            end
            uer_pkg::PH_TLOW: begin
              fin = 1'b1;
              if (tick_inc >= uer_pkg::LOW_TICKS) begin
                phase_nxt = uer_pkg::PH_THIGH;
                tick_nxt  = '0;
              end else begin
                tick_nxt = tick_inc;
              end
            end
            uer_pkg::PH_THIGH: begin
              fin      = 1'b1;
              fin_trig = 1'b1;
              if (tick_inc >= {12'd0, tw_eff}) begin
                phase_nxt = uer_pkg::PH_WAIT;
                tick_nxt  = '0;
              end else begin
                tick_nxt = tick_inc;
              end
            end
            uer_pkg::PH_WAIT: begin
              if (in_echo_level) begin
                ew_nxt = uer_pkg::EW_W'(1);
                if (cfg.timeout_us == 16'd0) begin
                  st_nxt    = uer_pkg::ST_BAD;
                  state_nxt = S_SHOT;
                end else begin
                  phase_nxt = uer_pkg::PH_MEAS;
                  fin       = 1'b1;
                end
              end else begin
                tick_nxt = tick_inc;
                if (tick_inc > {4'd0, cfg.timeout_us}) begin
                  st_nxt    = uer_pkg::ST_BAD;
                  state_nxt = S_SHOT;
                end else begin
                  fin = 1'b1;
                end
              end
            end
            uer_pkg::PH_MEAS: begin
              if (in_echo_level) begin
                ew_nxt = ew_inc;
                if (ew_inc > {1'b0, cfg.timeout_us}) begin
                  st_nxt    = uer_pkg::ST_BAD;
                  state_nxt = S_SHOT;
                end else begin
                  fin = 1'b1;
                end
              end else if (ew_r < {1'b0, cfg.near_width_us}) begin
                st_nxt    = uer_pkg::ST_NEAR;
                state_nxt = S_SHOT;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV1;
              end
            end
            uer_pkg::PH_GAP: begin
              tick_nxt = tick_inc;
              if (tick_inc >= cfg.gap_us) state_nxt = S_GAPOVER;
              else fin = 1'b1;
            end
            default: begin
              phase_nxt = uer_pkg::PH_IDLE;
              tick_nxt  = '0;
              fin       = 1'b1;
            end
          endcase
        end
      end

      S_DIV1: begin
        if (div_rsp.done) begin
          st_nxt    = uer_pkg::ST_VALID;
          dist_nxt  = div_rsp.quotient[uer_pkg::EW_W-1:0];
          state_nxt = S_SHOT;
        end
      end

      S_SHOT: begin
        if (!cfg.filter_mode) begin
          fin       = 1'b1;
          fin_done  = 1'b1;
          fin_st    = st_r;
          fin_dist  = (st_r == uer_pkg::ST_VALID) ? dist_r[15:0] : 16'd0;
          phase_nxt = uer_pkg::PH_IDLE;
          tick_nxt  = '0;
        end else begin
          shots_nxt = shots_r + uer_pkg::SAMPLE_BITS'(1);
          if (st_r == uer_pkg::ST_NEAR) begin
            fin       = 1'b1;
            fin_done  = 1'b1;
            fin_st    = uer_pkg::ST_NEAR;
            phase_nxt = uer_pkg::PH_IDLE;
            tick_nxt  = '0;
          end else begin
            if (st_r == uer_pkg::ST_VALID && dist_r > {9'd0, cfg.min_valid_cm}) begin
              sum_nxt   = sum_r + {(uer_pkg::SUM_W - uer_pkg::EW_W)'(0), dist_r};
              valid_nxt = valid_r + uer_pkg::SAMPLE_BITS'(1);
            end
            tick_nxt = '0;
            if (cfg.gap_us == 20'd0) begin
              state_nxt = S_GAPOVER;
            end else begin
              phase_nxt = uer_pkg::PH_GAP;
              fin       = 1'b1;
            end
          end
        end
      end

      S_GAPOVER: begin
        if (shots_r >= want) begin
          if (valid_r == '0) begin
            fin       = 1'b1;
            fin_done  = 1'b1;
            fin_st    = uer_pkg::ST_BAD;
            phase_nxt = uer_pkg::PH_IDLE;
            tick_nxt  = '0;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = sum_r;
            div_req.divisor  = uer_pkg::DIVS_W'(valid_r);
            state_nxt        = S_DIV2;
          end
        end else begin
          phase_nxt = uer_pkg::PH_TLOW;
          tick_nxt  = '0;
          ew_nxt    = '0;
          fin       = 1'b1;
        end
      end

      S_DIV2: begin
        if (div_rsp.done) begin
          fin       = 1'b1;
          fin_done  = 1'b1;
          fin_st    = uer_pkg::ST_VALID;
          fin_dist  = div_rsp.quotient[15:0];
          phase_nxt = uer_pkg::PH_IDLE;
          tick_nxt  = '0;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // tick finished: load the output register and take the next tick
    if (fin) begin
      state_nxt      = S_IDLE;
      out_valid_nxt  = 1'b1;
      out_trig_nxt   = fin_trig;
      out_done_nxt   = fin_done;
      out_status_nxt = fin_st;
      out_dist_nxt   = fin_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= uer_pkg::PH_IDLE;
      tick_r      <= '0;
      ew_r        <= '0;
      shots_r     <= '0;
      valid_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      tick_r      <= tick_nxt;
      ew_r        <= ew_nxt;
      shots_r     <= shots_nxt;
      valid_r     <= valid_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    st_r         <= st_nxt;
    dist_r       <= dist_nxt;
    out_trig_r   <= out_trig_nxt;
    out_done_r   <= out_done_nxt;
    out_status_r <= out_status_nxt;
    out_dist_r   <= out_dist_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_level = out_trig_r;
  assign out_done_res      = out_done_r;
  assign out_status        = out_status_r;
  assign out_distance_cm   = out_dist_r;

endmodule

// File: sv/uer_checker.sv
`timescale 1ns / 1ps
`include "ultrasonic_echo_ranger_assert.svh"
module uer_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_trigger_level,
  input logic        out_done_res,
  input logic [1:0]  out_status,
  input logic [15:0] out_distance_cm
);

  // a held result keeps its payload
  `UER_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_distance_cm) && $stable(out_done_res) && $stable(out_trigger_level), "result changed while stalled")

  // ticks without a measurement carry no status or distance
  `UER_ASSERT_NOW(a_idle_zero, clk, rst_n, out_valid && !out_done_res, out_status == uer_pkg::ST_VALID && out_distance_cm == 16'd0, "non-result tick has payload")

  // a distance only goes with a valid status
  `UER_ASSERT_NOW(a_dist_status, clk, rst_n, out_valid && out_status != uer_pkg::ST_VALID, out_distance_cm == 16'd0, "distance with bad status")

  // trigger pulse ticks never present a result
  `UER_ASSERT_NOW(a_trig_done, clk, rst_n, out_valid && out_trigger_level, !out_done_res, "result during trigger pulse")

  // after a tick transfer the block is either presenting or busy
  `UER_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && !in_stall, out_valid || in_stall, "tick lost after transfer")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_trigger_level (out_trigger_level),
  .out_done_res      (out_done_res),
  .out_status        (out_status),
  .out_distance_cm   (out_distance_cm)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic        trigger_level;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] distance_cm;
  } tick_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_start_req = 1'b0;
  logic                       in_echo_level = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_trigger_level;
  logic                       out_done_res;
  logic [1:0]                 out_status;
  logic [15:0]                out_distance_cm;
  logic                       cfg_we = 1'b0;
  logic [uer_pkg::CFG_AW-1:0] cfg_index = '0;
  logic [uer_pkg::CFG_DW-1:0] cfg_wdata = '0;

  ultrasonic_echo_ranger dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_start_req, .in_echo_level,
    .out_valid, .out_stall, .out_trigger_level, .out_done_res, .out_status,
    .out_distance_cm, .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ranger state mirrored for prediction
  uer_pkg::cfg_t regs;
  logic [2:0]    phase;
  logic [19:0]   ticks;
  logic [16:0]   echo_width;
  logic [7:0]    shots_done;
  logic [7:0]    shots_counted;
  logic [23:0]   dist_sum;
  tick_result_t  pending_res;

  tick_result_t expected_ticks[$];
  int mismatches = 0;
  int results_seen = 0;
  int ticks_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 25;
  int recv_stall_pct = 46;
  bit hold_off = 1'b0;

  function automatic void present_result(input logic [1:0] st, input logic [23:0] avg_cm);
    pending_res.done_res = 1'b1;
    pending_res.status = st;
    pending_res.distance_cm = (st == uer_pkg::ST_VALID) ? avg_cm[15:0] : 16'd0;
    phase = uer_pkg::PH_IDLE;
    ticks = '0;
  endfunction

  function automatic void begin_shot();
    phase = uer_pkg::PH_TLOW;
    ticks = '0;
    echo_width = '0;
  endfunction

  function automatic void finish_gap();
    logic [7:0] want_shots;
    want_shots = (regs.sample_count == 0) ? 8'd1 : regs.sample_count;
    if (shots_done >= want_shots) begin
      if (shots_counted == 0) present_result(uer_pkg::ST_BAD, '0);
      else present_result(uer_pkg::ST_VALID, dist_sum / 24'(shots_counted));
    end else begin
      begin_shot();
    end
  endfunction

  function automatic void end_shot(input logic timed_out);
    logic [1:0]  st;
    logic [16:0] shot_cm;
    logic [7:0]  divisor;
    st = uer_pkg::ST_BAD;
    shot_cm = '0;
    if (!timed_out) begin
      if (echo_width < {1'b0, regs.near_width_us}) begin
        st = uer_pkg::ST_NEAR;
      end else begin
        divisor = (regs.us_per_cm == 0) ? 8'd1 : regs.us_per_cm;
        st = uer_pkg::ST_VALID;
        shot_cm = echo_width / 17'(divisor);
      end
    end
    if (!regs.filter_mode) begin
      present_result(st, {7'd0, shot_cm});
      return;
    end
    shots_done++;
    // a near shot aborts the whole filtered run
    if (st == uer_pkg::ST_NEAR) begin
      present_result(uer_pkg::ST_NEAR, '0);
      return;
    end
    if (st == uer_pkg::ST_VALID && shot_cm > 17'(regs.min_valid_cm)) begin
      dist_sum = dist_sum + 24'(shot_cm);
      shots_counted++;
    end
    ticks = '0;
    if (regs.gap_us == 0) finish_gap();
    else phase = uer_pkg::PH_GAP;
  endfunction

  function automatic tick_result_t range_tick(input logic start, input logic echo);
    logic [7:0] trig_w;
    pending_res = '0;
    case (phase)
      uer_pkg::PH_IDLE: begin
        if (start) begin
          shots_done = '0;
          shots_counted = '0;
          dist_sum = '0;
          begin_shot();
        end
      end
      uer_pkg::PH_TLOW: begin
        ticks++;
        if (ticks >= uer_pkg::LOW_TICKS) begin
          phase = uer_pkg::PH_THIGH;
          ticks = '0;
        end
      end
      uer_pkg::PH_THIGH: begin
        pending_res.trigger_level = 1'b1;
        trig_w = (regs.trigger_width_us == 0) ? 8'd1 : regs.trigger_width_us;
        ticks++;
        if (ticks >= 20'(trig_w)) begin
          phase = uer_pkg::PH_WAIT;
          ticks = '0;
        end
      end
      uer_pkg::PH_WAIT: begin
        if (echo) begin
          echo_width = 17'd1;
          if (echo_width > 17'(regs.timeout_us)) end_shot(1'b1);
          else phase = uer_pkg::PH_MEAS;
        end else begin
          ticks++;
          if (ticks > 20'(regs.timeout_us)) end_shot(1'b1);
        end
      end
      uer_pkg::PH_MEAS: begin
        if (echo) begin
          echo_width++;
          if (echo_width > 17'(regs.timeout_us)) end_shot(1'b1);
        end else begin
          end_shot(1'b0);
        end
      end
      uer_pkg::PH_GAP: begin
        ticks++;
        if (ticks >= regs.gap_us) finish_gap();
      end
      default: begin
        phase = uer_pkg::PH_IDLE;
        ticks = '0;
      end
    endcase
    return pending_res;
  endfunction

  task automatic flag_error(input string what, input int got, input int want);
    mismatches++;
    $display("mismatch at result %0d, %s: got %0d expected %0d",
             results_seen, what, got, want);
  endtask

  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin : check_results
    tick_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        flag_error("result with no tick pending", 1, 0);
      end else begin
        exp_res = expected_ticks.pop_front();
        if (out_trigger_level !== exp_res.trigger_level)
          flag_error("trigger_level", int'(out_trigger_level), int'(exp_res.trigger_level));
        if (out_done_res !== exp_res.done_res)
          flag_error("done_res", int'(out_done_res), int'(exp_res.done_res));
        if (out_status !== exp_res.status)
          flag_error("status", int'(out_status), int'(exp_res.status));
        if (out_distance_cm !== exp_res.distance_cm)
          flag_error("distance_cm", int'(out_distance_cm), int'(exp_res.distance_cm));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // lowers valid and waits until every tick has its result back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_ticks.size() != 0);
  endtask

  task automatic send_tick(input logic start, input logic echo);
    if (hold_off) drain();
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_start_req  <= start;
    in_echo_level <= echo;
    do @(posedge clk); while (in_stall);
    expected_ticks.push_back(range_tick(start, echo));
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [uer_pkg::CFG_AW-1:0] idx, input int val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= uer_pkg::CFG_DW'(val);
    case (idx)
      uer_pkg::REG_TIMEOUT: regs.timeout_us       = val[15:0];
      uer_pkg::REG_NEAR:    regs.near_width_us    = val[15:0];
      uer_pkg::REG_UPC:     regs.us_per_cm        = val[7:0];
      uer_pkg::REG_TRIGW:   regs.trigger_width_us = val[7:0];
      uer_pkg::REG_SAMPLES: regs.sample_count     = val[7:0];
      uer_pkg::REG_GAP:     regs.gap_us           = val[19:0];
      uer_pkg::REG_MINCM:   regs.min_valid_cm     = val[7:0];
      uer_pkg::REG_FILTER:  regs.filter_mode      = val[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int t_out, input int near_w, input int upc, input int trig_w,
                          input int samples, input int gap, input int min_cm, input int filt);
    write_reg(uer_pkg::REG_TIMEOUT, t_out);
    write_reg(uer_pkg::REG_NEAR, near_w);
    write_reg(uer_pkg::REG_UPC, upc);
    write_reg(uer_pkg::REG_TRIGW, trig_w);
    write_reg(uer_pkg::REG_SAMPLES, samples);
    write_reg(uer_pkg::REG_GAP, gap);
    write_reg(uer_pkg::REG_MINCM, min_cm);
    write_reg(uer_pkg::REG_FILTER, filt);
  endtask

  // one measurement from start to result; echo delay and width are rolled per shot
  task automatic range_run(input int delay_lo, input int delay_hi,
                           input int width_lo, input int width_hi);
    int delay_t;
    int width_t;
    delay_t = $urandom_range(delay_hi, delay_lo);
    width_t = $urandom_range(width_hi, width_lo);
    send_tick(1'b1, 1'($urandom_range(1)));
    while (phase != uer_pkg::PH_IDLE) begin
      if (phase == uer_pkg::PH_WAIT) begin
        send_tick(1'($urandom_range(1)), int'(ticks) >= delay_t);
      end else if (phase == uer_pkg::PH_MEAS) begin
        send_tick(1'($urandom_range(1)), int'(echo_width) < width_t);
      end else begin
        delay_t = $urandom_range(delay_hi, delay_lo);
        width_t = $urandom_range(width_hi, width_lo);
        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  task automatic idle_noise(input int n);
    repeat (n) send_tick($urandom_range(7) == 0, 1'($urandom_range(1)));
  endtask

  task automatic test_single_mode();
    set_regs(10, 4, 2, 1, 1, 3, 2, 0);
    range_run(1, 1, 9, 9);
    range_run(0, 0, 2, 2);
    // width equal to the near threshold is a distance
    range_run(0, 0, 4, 4);
    // no echo within the timeout, then echo as long as the timeout, then one longer
    range_run(11, 11, 1, 1);
    range_run(0, 0, 10, 10);
    range_run(0, 0, 11, 11);
    // zero timeout, zero divisor, zero trigger width
    set_regs(0, 0, 0, 0, 0, 0, 0, 0);
    range_run(0, 0, 1, 1);
    range_run(1, 1, 1, 1);
    write_reg(uer_pkg::REG_TIMEOUT, 5);
    range_run(0, 0, 3, 3);
  endtask

  task automatic test_filter_mode();
    set_regs(12, 3, 2, 2, 3, 2, 1, 1);
    range_run(0, 2, 6, 10);
    range_run(0, 0, 2, 2);
    range_run(0, 0, 13, 13);
    // shots at the minimum distance are dropped
    write_reg(uer_pkg::REG_MINCM, 3);
    range_run(0, 0, 6, 6);
    range_run(0, 1, 6, 12);
    write_reg(uer_pkg::REG_GAP, 0);
    range_run(0, 1, 8, 12);
    write_reg(uer_pkg::REG_SAMPLES, 0);
    range_run(0, 0, 9, 9);
    write_reg(uer_pkg::REG_SAMPLES, 4);
    write_reg(uer_pkg::REG_MINCM, 0);
    range_run(0, 14, 1, 14);
  endtask

  task automatic test_live_registers();
    set_regs(20, 2, 3, 1, 1, 0, 0, 0);
    send_tick(1'b1, 1'b0);
    while (!(phase == uer_pkg::PH_MEAS && echo_width == 8))
      send_tick(1'b0, phase == uer_pkg::PH_WAIT || phase == uer_pkg::PH_MEAS);
    write_reg(uer_pkg::REG_UPC, 4);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    while (!(phase == uer_pkg::PH_WAIT && ticks == 3)) send_tick(1'b0, 1'b0);
    write_reg(uer_pkg::REG_TIMEOUT, 1);
    send_tick(1'b0, 1'b0);
  endtask

  task automatic test_extreme_registers();
    set_regs(65535, 65535, 255, 255, 255, 1048575, 255, 0);
    range_run(0, 0, 3, 3);
    write_reg(uer_pkg::REG_NEAR, 0);
    write_reg(uer_pkg::REG_TRIGW, 1);
    range_run(0, 0, 260, 260);
    write_reg(uer_pkg::REG_NEAR, 65535);
    write_reg(uer_pkg::REG_FILTER, 1);
    range_run(0, 0, 2, 2);
  endtask

  task automatic test_sender_pause();
    set_regs(8, 2, 2, 1, 2, 1, 0, 1);
    hold_off = 1'b1;
    range_run(0, 2, 1, 9);
    range_run(0, 2, 1, 9);
    hold_off = 1'b0;
  endtask

  task automatic test_random_runs(input int n_ticks);
    int stop_at;
    int t_out;
    stop_at = ticks_sent + n_ticks;
    set_regs(20, 4, 3, 1, 2, 2, 2, 1);
    while (ticks_sent < stop_at) begin
      if ($urandom_range(5) == 0) begin
        t_out = ($urandom_range(9) == 0) ? 0 : $urandom_range(30, 1);
        set_regs(t_out, $urandom_range(12), $urandom_range(6), $urandom_range(3),
                 $urandom_range(4), $urandom_range(4), $urandom_range(6), $urandom_range(1));
      end
      if ($urandom_range(9) == 0) idle_noise($urandom_range(4, 1));
      else if ($urandom_range(3) == 0) range_run(0, regs.timeout_us + 2, 1, regs.timeout_us + 2);
      else range_run(0, 3, 1, regs.timeout_us + 2);
      if ($urandom_range(15) == 0) drain();
    end
  endtask

  initial begin
    regs = '{timeout_us: 16'd30000, near_width_us: 16'd150, us_per_cm: 8'd58,
             trigger_width_us: 8'd20, sample_count: 8'd1, gap_us: 20'd20000,
             min_valid_cm: 8'd2, filter_mode: 1'b0};
    phase = uer_pkg::PH_IDLE;
    ticks = '0;
    echo_width = '0;
    shots_done = '0;
    shots_counted = '0;
    dist_sum = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_single_mode();
    test_filter_mode();
    test_live_registers();
    test_extreme_registers();
    test_sender_pause();
    test_random_runs(180);
    send_idle_pct = 46;
    recv_stall_pct = 25;
    test_random_runs(180);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_runs(180);
    drain();
    repeat (80) @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
